@@ design/mavlink_frame_receiver_assert.svh @@
// ----------------------------------------------------------------------------
// mavlink_frame_receiver_assert.svh
// Assertion macros shared by the frame receiver RTL.
// ----------------------------------------------------------------------------
`ifndef MAVLINK_FRAME_RECEIVER_ASSERT_SVH
`define MAVLINK_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define MFR_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off during reset.
`define MFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ design/mfr_pkg.sv @@
// ----------------------------------------------------------------------------
// mfr_pkg
// Constants, result word layout and CRC helpers for the frame receiver.
// ----------------------------------------------------------------------------
package mfr_pkg;

    localparam int unsigned PosW = 9;

    localparam logic [7:0] STX_V1 = 8'hFE;
    localparam logic [7:0] STX_V2 = 8'hFD;

    localparam logic [PosW-1:0] HDR_V1  = 9'd6;
    localparam logic [PosW-1:0] HDR_V2  = 9'd10;
    localparam logic [PosW-1:0] SIG_LEN = 9'd13;

    localparam logic [PosW-1:0] POS_LEN   = 9'd1;
    localparam logic [PosW-1:0] POS_FLAGS = 9'd2;
    localparam logic [PosW-1:0] POS_ID_V1 = 9'd5;
    localparam logic [PosW-1:0] POS_ID0   = 9'd7;
    localparam logic [PosW-1:0] POS_ID1   = 9'd8;
    localparam logic [PosW-1:0] POS_ID2   = 9'd9;
    // Longest frame: v2 header, full payload, CRC and signature.
    localparam logic [PosW-1:0] POS_MAX   = 9'd280;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic KIND_PAYLOAD   = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    localparam int unsigned DataW = 56;

    // Result fields, payload_byte in the lowest bits.
    typedef struct packed {
        logic        version_two;
        logic        signed_frame;
        logic        known_message;
        logic        crc_good;
        logic [7:0]  payload_length;
        logic [23:0] message_id;
        logic [7:0]  payload_offset;
        logic [7:0]  payload_byte;
    } t_result;

    // One byte of CRC-16/MCRF4XX.
    function automatic logic [15:0] crc_step(input logic [7:0] b, input logic [15:0] crc);
        logic [7:0] t;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
    endfunction

    function automatic logic [7:0] msg_crc_seed(input logic [23:0] id);
        logic [7:0] e;
        case (id)
            24'd0:   e = 8'd50;
            24'd1:   e = 8'd124;
            24'd24:  e = 8'd24;
            24'd30:  e = 8'd39;
            24'd74:  e = 8'd20;
            default: e = 8'd0;
        endcase
        return e;
    endfunction

    function automatic logic known_id(input logic [23:0] id);
        return (id == 24'd0) || (id == 24'd1) || (id == 24'd24) ||
               (id == 24'd30) || (id == 24'd74);
    endfunction

endpackage

@@ design/mavlink_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// mavlink_frame_receiver
// A word accepted at the input is registered in the input register and, once
// the result slot is free, its result is registered in the result register.
// Throughput: one byte per cycle while results are taken; a waiting result
// holds the parser and lets at most one more word into the input register.
// Reset (synchronous, active low) empties both registers and returns the
// parser to hunting for a start byte with the CRC preset to all ones.
// ----------------------------------------------------------------------------
`include "mavlink_frame_receiver_assert.svh"

module mavlink_frame_receiver
    import mfr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Byte stream in
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [7:0]       i_s_axis_tdata,   // [7:0] rx_byte
    // Results out
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // [7:0] payload_byte, [15:8] payload_offset, [39:16] message_id,
    // [47:40] payload_length, [48] crc_good, [49] known_message,
    // [50] signed_frame, [51] version_two, [55:52] zero
    output logic [DataW-1:0] o_m_axis_tdata,
    output logic             o_m_axis_tuser    // [0] kind: 0 payload, 1 frame end
);

    // Input register
    logic            r_s1_valid;
    logic [7:0]      r_s1_byte;

    // Parser state
    logic [PosW-1:0] r_pos;        // 0 while hunting, else index of next byte
    logic            r_v2;
    logic [7:0]      r_len;
    logic            r_sig;
    logic [23:0]     r_id;
    logic [15:0]     r_crc;
    logic [15:0]     r_rcv;

    // Result register
    logic            r_out_valid;
    logic            r_out_kind;
    t_result         r_out;

    logic            adv;
    logic            proc;
    logic [7:0]      b;
    logic [PosW-1:0] hdr;
    logic [PosW-1:0] body_end;
    logic [PosW-1:0] last_idx;
    logic            hunting;
    logic            in_body;
    logic            emit_payload;
    logic            emit_end;
    logic [15:0]     rcv_full;
    logic [15:0]     crc_fin;
    logic [PosW-1:0] offset_wide;

    // Advance the pipe when the result slot is free or being taken.
    assign adv             = !r_out_valid || i_m_axis_tready;
    assign proc            = r_s1_valid && adv;
    assign o_s_axis_tready = !r_s1_valid || adv;

    assign b       = r_s1_byte;
    assign hunting = (r_pos == '0);
    assign hdr     = r_v2 ? HDR_V2 : HDR_V1;
    // Length is captured at index 1, long before any test below can match.
    assign body_end = hdr + {1'b0, r_len};
    assign last_idx = body_end + 9'd1 + ((r_v2 && r_sig) ? SIG_LEN : 9'd0);
    assign in_body  = (r_pos < body_end);

    assign emit_payload = !hunting && in_body && (r_pos >= hdr);
    assign emit_end     = !hunting && (r_pos == last_idx);

    // The high CRC byte may arrive in the very cycle that closes the frame.
    assign rcv_full    = (r_pos == body_end + 9'd1) ? {b, r_rcv[7:0]} : r_rcv;
    assign crc_fin     = crc_step(msg_crc_seed(r_id), r_crc);
    assign offset_wide = r_pos - hdr;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
        if (o_s_axis_tready) begin
            r_s1_byte <= i_s_axis_tdata;
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_v2  <= 1'b0;
            r_len <= '0;
            r_sig <= 1'b0;
            r_id  <= '0;
            r_crc <= CRC_INIT;
            r_rcv <= '0;
        end else if (proc) begin
            if (hunting) begin
                // Drop anything that is not a start byte.
                if (b == STX_V1 || b == STX_V2) begin
                    r_pos <= 9'd1;
                    r_v2  <= (b == STX_V2);
                    r_len <= '0;
                    r_sig <= 1'b0;
                    r_id  <= '0;
                    r_crc <= CRC_INIT;
                    r_rcv <= '0;
                end
            end else begin
                r_pos <= emit_end ? '0 : r_pos + 9'd1;
                if (r_pos == POS_LEN) begin
                    r_len <= b;
                end
                if (r_v2 && r_pos == POS_FLAGS) begin
                    r_sig <= b[0];
                end
                if (!r_v2 && r_pos == POS_ID_V1) begin
                    r_id <= {16'h0000, b};
                end
                if (r_v2 && r_pos == POS_ID0) begin
                    r_id[7:0] <= r_id[7:0] | b;
                end
                if (r_v2 && r_pos == POS_ID1) begin
                    r_id[15:8] <= r_id[15:8] | b;
                end
                if (r_v2 && r_pos == POS_ID2) begin
                    r_id[23:16] <= r_id[23:16] | b;
                end
                // Header after the start byte and payload feed the CRC; then the two CRC bytes.
                if (in_body) begin
                    r_crc <= crc_step(b, r_crc);
                end else if (r_pos == body_end) begin
                    r_rcv[7:0] <= b;
                end else if (r_pos == body_end + 9'd1) begin
                    r_rcv[15:8] <= b;
                end
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= proc && (emit_payload || emit_end);
        end
        if (proc && (emit_payload || emit_end)) begin
            r_out_kind           <= emit_end ? KIND_FRAME_END : KIND_PAYLOAD;
            r_out.payload_byte   <= emit_end ? 8'h00 : b;
            r_out.payload_offset <= emit_end ? 8'h00 : offset_wide[7:0];
            r_out.message_id     <= r_id;
            r_out.payload_length <= r_len;
            r_out.crc_good       <= emit_end && (crc_fin == rcv_full);
            r_out.known_message  <= known_id(r_id);
            r_out.signed_frame   <= r_v2 && r_sig;
            r_out.version_two    <= r_v2;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tdata  = {{(DataW - $bits(t_result)){1'b0}}, r_out};

    // Checks
    `MFR_ASSERT_NEXT(a_hunt_silent, proc && hunting, !r_out_valid,
        "result produced while hunting")
    `MFR_ASSERT_NEXT(a_end_rehunt, proc && emit_end, r_pos == '0,
        "parser did not return to hunting after frame end")
    `MFR_ASSERT_IMPLY(a_pos_range, 1'b1, r_pos <= POS_MAX,
        "byte position beyond longest frame")
    `MFR_ASSERT_IMPLY(a_offset_in_len, r_out_valid && r_out_kind == KIND_PAYLOAD,
        r_out.payload_offset < r_out.payload_length,
        "payload offset not below payload length")

endmodule
